// ===== hw/rtl/mcpg_pkg.sv =====
`default_nettype none

package mcpg_pkg;

	// default geometry of the generator
	localparam int COORD_BITS_DEF  = 10;
	localparam int RADIUS_BITS_DEF = 9;

	// depth of the step queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// points emitted by one step and the width of their index
	localparam int POINTS_PER_STEP = 8;
	localparam int POINT_IDX_BITS  = 3;

	// command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/mcpg_front.sv =====
`default_nettype none

module mcpg_front #(
	parameter int COORD_BITS  = mcpg_pkg::COORD_BITS_DEF,
	parameter int RADIUS_BITS = mcpg_pkg::RADIUS_BITS_DEF,
	localparam int REC_W      = 2 * COORD_BITS + 2 * RADIUS_BITS + 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	output logic                        full,
	input  wire logic                   command,
	input  wire logic [COORD_BITS-1:0]  center_x,
	input  wire logic [COORD_BITS-1:0]  center_y,
	input  wire logic [RADIUS_BITS-1:0] radius,
	input  wire logic                   rec_full,
	output logic                        rec_push,
	output logic [REC_W-1:0]            rec_data
);

	localparam int DW = RADIUS_BITS + 3;
	localparam logic signed [DW-1:0] ONE = DW'(1);

	logic [RADIUS_BITS-1:0] offset_h_q;
	logic [RADIUS_BITS-1:0] offset_v_q;
	logic signed [DW-1:0]   decision_q;
	logic [COORD_BITS-1:0]  held_cx_q;
	logic [COORD_BITS-1:0]  held_cy_q;
	logic                   active_q;

	logic                   accept;
	logic                   do_step;
	logic [RADIUS_BITS-1:0] h_new;
	logic [RADIUS_BITS-1:0] v_new;
	logic signed [DW-1:0]   h_ext;
	logic signed [DW-1:0]   v_ext;
	logic signed [DW-1:0]   d_new;
	logic                   still_active;

	// hold off the producer while the step queue is full
	assign full    = rec_full;
	assign accept  = push && !rec_full;
	assign do_step = accept && (command == mcpg_pkg::CMD_STEP) && active_q
		&& (offset_v_q > offset_h_q);

	// one midpoint iteration
	always_comb begin
		h_new = offset_h_q + RADIUS_BITS'(1);
		if (decision_q < 0) begin
			v_new = offset_v_q;
		end else begin
			v_new = offset_v_q - RADIUS_BITS'(1);
		end
		h_ext = $signed({3'b000, h_new});
		v_ext = $signed({3'b000, v_new});
		if (decision_q < 0) begin
			d_new = decision_q + (h_ext <<< 1) + ONE;
		end else begin
			d_new = decision_q + ((h_ext - v_ext) <<< 1) + ONE;
		end
		still_active = v_new > h_new;
	end

	// update circle state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_h_q <= '0;
			offset_v_q <= '0;
			decision_q <= '0;
			held_cx_q  <= '0;
			held_cy_q  <= '0;
			active_q   <= 1'b0;
		end else if (accept) begin
			if (command == mcpg_pkg::CMD_START) begin
				held_cx_q  <= center_x;
				held_cy_q  <= center_y;
				offset_h_q <= '0;
				offset_v_q <= radius;
				decision_q <= ONE - $signed({3'b000, radius});
				active_q   <= radius != '0;
			end else if (do_step) begin
				offset_h_q <= h_new;
				offset_v_q <= v_new;
				decision_q <= d_new;
				active_q   <= still_active;
			end
		end
	end

	// hand the updated offsets to the back end
	assign rec_push = do_step;
	assign rec_data = {!still_active, held_cy_q, held_cx_q, v_new, h_new};

endmodule

`default_nettype wire

// ===== hw/rtl/mcpg_queue.sv =====
`default_nettype none

module mcpg_queue #(
	parameter int WIDTH = 1,
	parameter int DEPTH = mcpg_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  q_full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  q_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = count_q == CW'(DEPTH);
	assign q_empty = count_q == '0;
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	// store entries
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mcpg_back.sv =====
`default_nettype none

module mcpg_back #(
	parameter int COORD_BITS  = mcpg_pkg::COORD_BITS_DEF,
	parameter int RADIUS_BITS = mcpg_pkg::RADIUS_BITS_DEF,
	localparam int REC_W      = 2 * COORD_BITS + 2 * RADIUS_BITS + 1,
	localparam int OUT_BITS   = COORD_BITS + 2
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       rec_empty,
	input  wire logic [REC_W-1:0]           rec_data,
	output logic                            rec_pop,
	output logic                            empty,
	input  wire logic                       pop,
	output logic signed [OUT_BITS-1:0]      point_x,
	output logic signed [OUT_BITS-1:0]      point_y,
	output logic                            last_of_step,
	output logic                            circle_done
);

	localparam int IB = mcpg_pkg::POINT_IDX_BITS;
	localparam int W  = OUT_BITS + RADIUS_BITS;
	localparam logic [IB-1:0] LAST_IDX = IB'(mcpg_pkg::POINTS_PER_STEP - 1);

	logic [REC_W-1:0]          rec_q;
	logic                      rec_valid_q;
	logic [IB-1:0]             idx_q;
	logic                      out_valid_q;
	logic [OUT_BITS-1:0]       px_q;
	logic [OUT_BITS-1:0]       py_q;
	logic                      last_q;
	logic                      done_q;

	logic [RADIUS_BITS-1:0]    rh;
	logic [RADIUS_BITS-1:0]    rv;
	logic [COORD_BITS-1:0]     rcx;
	logic [COORD_BITS-1:0]     rcy;
	logic                      rdone;
	logic                      out_take;
	logic                      load_out;
	logic                      rec_free;
	logic [W-1:0]              xa;
	logic [W-1:0]              ya;
	logic [W-1:0]              cxw;
	logic [W-1:0]              cyw;
	logic [W-1:0]              px_w;
	logic [W-1:0]              py_w;

	assign {rdone, rcy, rcx, rv, rh} = rec_q;

	// handshake between record, point index and output register
	assign out_take = pop && out_valid_q;
	assign load_out = rec_valid_q && (!out_valid_q || out_take);
	assign rec_free = !rec_valid_q || (load_out && (idx_q == LAST_IDX));
	assign rec_pop  = rec_free && !rec_empty;

	// pick the octant: bit 2 swaps offsets, bit 1 negates x, bit 0 negates y
	always_comb begin
		cxw = W'(rcx);
		cyw = W'(rcy);
		xa  = idx_q[2] ? W'(rv) : W'(rh);
		ya  = idx_q[2] ? W'(rh) : W'(rv);
		px_w = idx_q[1] ? (cxw - xa) : (cxw + xa);
		py_w = idx_q[0] ? (cyw - ya) : (cyw + ya);
	end

	// hold the current step record and walk its eight points
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rec_free) begin
				rec_valid_q <= !rec_empty;
			end
			if (load_out) begin
				idx_q <= idx_q + IB'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rec_pop) begin
			rec_q <= rec_data;
		end
		if (load_out) begin
			px_q   <= px_w[OUT_BITS-1:0];
			py_q   <= py_w[OUT_BITS-1:0];
			last_q <= idx_q == LAST_IDX;
			done_q <= rdone;
		end
	end

	assign empty        = !out_valid_q;
	assign point_x      = $signed(px_q);
	assign point_y      = $signed(py_q);
	assign last_of_step = last_q;
	assign circle_done  = done_q;

	// a waiting point is never overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> (out_valid_q && $stable(px_q) && $stable(py_q)))
		else $error("waiting point changed before transfer");

	// the point index rests at zero between records
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!rec_valid_q |-> (idx_q == '0))
		else $error("point index not at zero without a record");

	// a freed slot with a queued record is refilled next cycle
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_free && !rec_empty) |=> rec_valid_q)
		else $error("record slot not refilled");

	// the eighth point of a step closes its record
	a_last_close: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && (idx_q == LAST_IDX) && rec_empty) |=> !rec_valid_q)
		else $error("record kept after its last point");

endmodule

`default_nettype wire

// ===== hw/rtl/midpoint_circle_point_generator_unit.sv =====
// Path: a step command enters the step queue, then the record register; its first point
// then goes to the output register. Throughput: one point per cycle from the output register
// while pop is held; a start command emits nothing.
// Steps are queued between the front and back ends, so the input stalls only when
// the step queue is full while the back end walks its points.
// Reset: arst_n asynchronous active low clears all control state; no circle active.
`default_nettype none

module midpoint_circle_point_generator_unit #(
	parameter int COORD_BITS  = mcpg_pkg::COORD_BITS_DEF,
	parameter int RADIUS_BITS = mcpg_pkg::RADIUS_BITS_DEF,
	localparam int OUT_BITS   = COORD_BITS + 2
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	output logic                        full,
	input  wire logic                   command,
	input  wire logic [COORD_BITS-1:0]  center_x,
	input  wire logic [COORD_BITS-1:0]  center_y,
	input  wire logic [RADIUS_BITS-1:0] radius,
	output logic                        empty,
	input  wire logic                   pop,
	output logic signed [OUT_BITS-1:0]  point_x,
	output logic signed [OUT_BITS-1:0]  point_y,
	output logic                        last_of_step,
	output logic                        circle_done
);

	localparam int REC_W = 2 * COORD_BITS + 2 * RADIUS_BITS + 1;

	logic             rec_push;
	logic [REC_W-1:0] rec_wdata;
	logic             rec_full;
	logic             rec_pop;
	logic [REC_W-1:0] rec_rdata;
	logic             rec_empty;

	// accept commands and run the midpoint iteration
	mcpg_front #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.command  (command),
		.center_x (center_x),
		.center_y (center_y),
		.radius   (radius),
		.rec_full (rec_full),
		.rec_push (rec_push),
		.rec_data (rec_wdata)
	);

	// decouple iteration from point emission
	mcpg_queue #(
		.WIDTH (REC_W),
		.DEPTH (mcpg_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_push),
		.wr_data (rec_wdata),
		.q_full  (rec_full),
		.rd_en   (rec_pop),
		.rd_data (rec_rdata),
		.q_empty (rec_empty)
	);

	// emit the eight symmetric points of each step
	mcpg_back #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec_empty    (rec_empty),
		.rec_data     (rec_rdata),
		.rec_pop      (rec_pop),
		.empty        (empty),
		.pop          (pop),
		.point_x      (point_x),
		.point_y      (point_y),
		.last_of_step (last_of_step),
		.circle_done  (circle_done)
	);

endmodule

`default_nettype wire
